[hdl/assert_macros.svh]
// Assertion helpers for the duplicate cache. The clock is clk and the
// asynchronous active-low reset is rst_n in every module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition a implies condition b in the same cycle.
`define ASSERT_IMPLIES(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");
// Condition a implies condition b in the next cycle.
`define ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");
// Condition a never holds.
`define ASSERT_NEVER(label, a) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(a)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_IMPLIES(label, a, b)
`define ASSERT_NEXT(label, a, b)
`define ASSERT_NEVER(label, a)
`endif
`endif

[hdl/rrdc_pkg.sv]
package rrdc_pkg;

    // Default table depth and register reset value.
    localparam int ENTRIES_DEFAULT = 64;
    localparam logic [15:0] LIFETIME_RESET = 16'd5600;

    localparam int MAC_W = 48;
    localparam int ID_W = 32;
    localparam int TIME_W = 32;
    localparam int LIFE_W = 16;

    // Register byte address bit that selects the word.
    localparam logic REG_LIFETIME = 1'b0;

    // One table slot as held in the table memory.
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] stamp;
        logic [ID_W-1:0]   request_id;
        logic [MAC_W-1:0]  mac;
    } entry_t;

    // Verdict of the compare unit on one slot.
    typedef struct packed {
        logic expired;
        logic live;
        logic match;
        logic newer;
    } scan_flags_t;

    // One result item.
    typedef struct packed {
        logic table_full;
        logic accepted;
    } result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

endpackage

[hdl/route_request_duplicate_cache_unit.sv]
// Channel   Direction  Transfer contents
// s_*       in         source_mac, request_id, now_ms
// m_*       out        accepted, table_full
// APB       in/out     lifetime_ms register at byte address 0
//
// An item keeps the block busy from its transfer until it is ready again,
// and no new item is taken meanwhile: one table read per slot through the
// single read port, a drain state for the read pipeline, a finish state to
// update the table. After reset every slot is cleared before the first item.
// A result waits in an output register; only a stalled result with a second
// one finished holds the block in its final cycle.
`include "assert_macros.svh"

module route_request_duplicate_cache_unit
    import rrdc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    // Input stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,  // source_mac[47:0], request_id[79:48], now_ms[111:80]
    // Output stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,  // accepted[0], table_full[1], zero[7:2]
    // Configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int IDX_W = $clog2(ENTRIES);

    logic [LIFE_W-1:0] lifetime_reg;
    logic              m_tvalid_reg;
    result_t           res_reg;
    logic              res_free;
    logic              res_load;
    result_t           res;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    entry_t            rd_data;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;
    state_t            state;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LIFETIME) ? {16'd0, lifetime_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lifetime_reg <= LIFETIME_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_LIFETIME))
        begin
            lifetime_reg <= pwdata[LIFE_W-1:0];
        end
    end

    rrdc_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .lifetime_ms (lifetime_reg),
        .item_valid  (s_tvalid),
        .item_ready  (s_tready),
        .item_mac    (s_tdata[47:0]),
        .item_id     (s_tdata[79:48]),
        .item_now    (s_tdata[111:80]),
        .res_free    (res_free),
        .res_load    (res_load),
        .res         (res),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .state       (state)
    );

    rrdc_table #(
        .ENTRIES (ENTRIES)
    ) u_table (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Output register that holds a result until its transfer.
    assign res_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            m_tvalid_reg <= res_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, res_reg.table_full, res_reg.accepted};

    // A result is never both accepted and rejected for lack of space.
    `ASSERT_NEVER(a_result_exclusive, m_tvalid && m_tdata[0] && m_tdata[1])
    // The block is busy for the whole scan once an item is taken.
    `ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    // The table is never written while the block waits for an item.
    `ASSERT_NEVER(a_no_write_when_idle, wr_en && s_tready)
    // A fresh result is loaded only from the final cycle of an item.
    `ASSERT_IMPLIES(a_load_from_finish, res_load, state == ST_FINISH)

endmodule

[hdl/rrdc_table.sv]
module rrdc_table
    import rrdc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [$clog2(ENTRIES)-1:0] rd_addr,
    output entry_t                     rd_data,
    input  logic                       wr_en,
    input  logic [$clog2(ENTRIES)-1:0] wr_addr,
    input  entry_t                     wr_data
);

    entry_t mem [ENTRIES];
    entry_t rd_data_reg;

    // One write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // One read port with registered data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/rrdc_scan_unit.sv]
module rrdc_scan_unit
    import rrdc_pkg::*;
(
    input  entry_t              entry,
    input  logic [MAC_W-1:0]    mac,
    input  logic [ID_W-1:0]     request_id,
    input  logic [TIME_W-1:0]   now_ms,
    input  logic [LIFE_W-1:0]   lifetime_ms,
    output scan_flags_t         flags
);

    logic [TIME_W-1:0] age;

    // Modular age of the slot, then the expiry compare.
    assign age = now_ms - entry.stamp;

    always_comb
    begin
        flags.expired = entry.valid && (age >= {{(TIME_W-LIFE_W){1'b0}}, lifetime_ms});
        flags.live    = entry.valid && !flags.expired;
        flags.match   = flags.live && (entry.mac == mac);
        flags.newer   = entry.request_id < request_id;
    end

endmodule

[hdl/rrdc_ctrl.sv]
module rrdc_ctrl
    import rrdc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [LIFE_W-1:0]          lifetime_ms,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  logic [MAC_W-1:0]           item_mac,
    input  logic [ID_W-1:0]            item_id,
    input  logic [TIME_W-1:0]          item_now,
    input  logic                       res_free,
    output logic                       res_load,
    output result_t                    res,
    output logic                       rd_en,
    output logic [$clog2(ENTRIES)-1:0] rd_addr,
    input  entry_t                     rd_data,
    output logic                       wr_en,
    output logic [$clog2(ENTRIES)-1:0] wr_addr,
    output entry_t                     wr_data,
    output state_t                     state
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic              pipe_vld_reg;
    logic [IDX_W-1:0]  pipe_idx_reg;
    logic              hit_found_reg, hit_found_next;
    logic              hit_newer_reg, hit_newer_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic              free_found_reg, free_found_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic [MAC_W-1:0]  mac_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] now_reg;
    logic              accept;
    scan_flags_t       flags;
    entry_t            new_entry;

    assign accept = item_valid && (state_reg == ST_IDLE);
    assign state  = state_reg;

    // Shared compare unit, fed with one slot per cycle.
    rrdc_scan_unit u_scan (
        .entry       (rd_data),
        .mac         (mac_reg),
        .request_id  (id_reg),
        .now_ms      (now_reg),
        .lifetime_ms (lifetime_ms),
        .flags       (flags)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                    cnt_next   = '0;
                end
            end
            ST_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                    cnt_next   = '0;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Track the first live match and the first free slot as data returns.
    always_comb
    begin
        hit_found_next  = hit_found_reg;
        hit_newer_next  = hit_newer_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        if (accept)
        begin
            hit_found_next  = 1'b0;
            free_found_next = 1'b0;
        end
        else if (pipe_vld_reg)
        begin
            if (flags.match && !hit_found_reg)
            begin
                hit_found_next = 1'b1;
                hit_newer_next = flags.newer;
                hit_idx_next   = pipe_idx_reg;
            end
            if (!flags.live && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = pipe_idx_reg;
            end
        end
    end

    assign new_entry = '{valid: 1'b1, stamp: now_reg, request_id: id_reg, mac: mac_reg};

    // Outputs: memory ports, handshake and result.
    always_comb
    begin
        item_ready     = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = cnt_reg;
        wr_en          = 1'b0;
        wr_addr        = cnt_reg;
        wr_data        = '0;
        res_load       = 1'b0;
        res.accepted   = 1'b0;
        res.table_full = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
            end
            ST_IDLE:
            begin
                item_ready = 1'b1;
            end
            ST_SCAN, ST_DRAIN:
            begin
                rd_en = (state_reg == ST_SCAN);
                // Drop an expired slot right after it is read.
                if (pipe_vld_reg && flags.expired)
                begin
                    wr_en         = 1'b1;
                    wr_addr       = pipe_idx_reg;
                    wr_data       = rd_data;
                    wr_data.valid = 1'b0;
                end
            end
            ST_FINISH:
            begin
                res_load = res_free;
                wr_data  = new_entry;
                if (hit_found_reg)
                begin
                    wr_en        = res_free && hit_newer_reg;
                    wr_addr      = hit_idx_reg;
                    res.accepted = hit_newer_reg;
                end
                else if (free_found_reg)
                begin
                    wr_en        = res_free;
                    wr_addr      = free_idx_reg;
                    res.accepted = 1'b1;
                end
                else
                begin
                    res.table_full = 1'b1;
                end
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            pipe_vld_reg   <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pipe_vld_reg   <= (state_reg == ST_SCAN);
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
        end
    end

    // Item and slot payload.
    always_ff @(posedge clk)
    begin
        pipe_idx_reg  <= cnt_reg;
        hit_newer_reg <= hit_newer_next;
        hit_idx_reg   <= hit_idx_next;
        free_idx_reg  <= free_idx_next;
        if (accept)
        begin
            mac_reg <= item_mac;
            id_reg  <= item_id;
            now_reg <= item_now;
        end
    end

endmodule

[test/route_request_duplicate_cache_checker.sv]
`timescale 1ns / 1ps

module route_request_duplicate_cache_checker
    import rrdc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [111:0] s_tdata,  // source_mac[47:0], request_id[79:48], now_ms[111:80]
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [7:0]   m_tdata,  // accepted[0], table_full[1], zero[7:2]
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic [31:0]  prdata,
    input  logic         pready,
    output int           error_count,
    output int           verdicts_owed
);

    // Shadow copy of the register and of the source table.
    logic [LIFE_W-1:0] lifetime_ms;
    logic              slot_live [ENTRIES];
    logic [MAC_W-1:0]  slot_mac [ENTRIES];
    logic [ID_W-1:0]   slot_req_id [ENTRIES];
    logic [TIME_W-1:0] slot_stamp [ENTRIES];

    // Verdicts still owed by the block, oldest first.
    result_t verdict_q [$];
    result_t oldest;

    // Age out stale sources, then look the request up and update the table.
    function automatic result_t judge_request(input logic [MAC_W-1:0] mac,
                                              input logic [ID_W-1:0] req_id,
                                              input logic [TIME_W-1:0] now_ms);
        int hit;
        int free_slot;
        logic [TIME_W-1:0] age;
        result_t verdict;
        hit = -1;
        free_slot = -1;
        verdict = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            age = now_ms - slot_stamp[i];
            if (slot_live[i] && age >= TIME_W'(lifetime_ms))
                slot_live[i] = 1'b0;
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (slot_live[i])
            begin
                if (hit < 0 && slot_mac[i] == mac)
                    hit = i;
            end
            else if (free_slot < 0)
            begin
                free_slot = i;
            end
        end
        if (hit >= 0)
        begin
            // Only a strictly larger id refreshes a known source.
            if (slot_req_id[hit] < req_id)
            begin
                slot_req_id[hit] = req_id;
                slot_stamp[hit] = now_ms;
                verdict.accepted = 1'b1;
            end
        end
        else if (free_slot >= 0)
        begin
            slot_live[free_slot] = 1'b1;
            slot_mac[free_slot] = mac;
            slot_req_id[free_slot] = req_id;
            slot_stamp[free_slot] = now_ms;
            verdict.accepted = 1'b1;
        end
        else
        begin
            verdict.table_full = 1'b1;
        end
        return verdict;
    endfunction

    // Count a failure; only the first ten are described.
    task automatic note_error(input string what);
        error_count++;
        if (error_count <= 10)
            $display("%0t ns: %s", $realtime, what);
    endtask

    // Follow register accesses and both stream channels.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lifetime_ms = LIFETIME_RESET;
            for (int i = 0; i < ENTRIES; i++)
                slot_live[i] = 1'b0;
            verdict_q.delete();
            error_count = 0;
            verdicts_owed = 0;
        end
        else
        begin
            if (psel && penable && pready && paddr[2] == REG_LIFETIME)
            begin
                if (pwrite)
                    lifetime_ms = pwdata[LIFE_W-1:0];
                else if (prdata !== 32'(lifetime_ms))
                    note_error($sformatf("lifetime read: expected %0d, got %0d",
                                         lifetime_ms, prdata));
            end

            // Compare an outgoing transfer with the oldest verdict.
            if (m_tvalid && m_tready)
            begin
                if (verdict_q.size() == 0)
                begin
                    note_error($sformatf("result transfer 8'h%02h with none owed", m_tdata));
                end
                else
                begin
                    oldest = verdict_q.pop_front();
                    if (m_tdata[0] !== oldest.accepted || m_tdata[1] !== oldest.table_full
                        || m_tdata[7:2] !== 6'd0)
                        note_error($sformatf({"result: expected accepted=%b table_full=%b,",
                                              " got accepted=%b table_full=%b pad=%b"},
                                             oldest.accepted, oldest.table_full,
                                             m_tdata[0], m_tdata[1], m_tdata[7:2]));
                end
            end

            // Each incoming transfer owes exactly one verdict.
            if (s_tvalid && s_tready)
                verdict_q.push_back(judge_request(s_tdata[MAC_W-1:0],
                                                  s_tdata[MAC_W+ID_W-1:MAC_W],
                                                  s_tdata[MAC_W+ID_W+TIME_W-1:MAC_W+ID_W]));
            verdicts_owed = verdict_q.size();
        end
    end

endmodule

[test/route_request_duplicate_cache_unit_tb.sv]
`timescale 1ns / 1ps

module route_request_duplicate_cache_unit_tb;
    import rrdc_pkg::*;

    localparam int TABLE_DEPTH = ENTRIES_DEFAULT;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
    localparam int PHASE_ITEMS = 384;
    localparam logic [2:0] LIFETIME_ADDR = {REG_LIFETIME, 2'b00};

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;  // source_mac[47:0], request_id[79:48], now_ms[111:80]
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;  // accepted[0], table_full[1], zero[7:2]
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    int   error_count;
    int   verdicts_owed;
    int   sender_idle_pct;
    int   receiver_stall_pct;
    logic hold_off_req;
    int   quiet_cycles;

    // Source pool for the random traffic, with the highest id sent per source.
    logic [MAC_W-1:0]  mac_pool [128];
    logic [ID_W-1:0]   id_pool [128];
    logic [TIME_W-1:0] clock_ms;

    route_request_duplicate_cache_unit #(
        .ENTRIES (TABLE_DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    route_request_duplicate_cache_checker #(
        .ENTRIES (TABLE_DEPTH)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .error_count   (error_count),
        .verdicts_owed (verdicts_owed)
    );

    // 100 MHz clock.
    initial
        clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort when no transfer happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("route_request_duplicate_cache_unit_tb: errors");
                $finish;
            end
        end
    end

    // Result side: random stalls, or one long hold-off on request.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            end
        end
    end

    // Offer one request and hold it until the transfer completes.
    task automatic send_request(input logic [MAC_W-1:0] mac, input logic [ID_W-1:0] req_id,
                                input logic [TIME_W-1:0] now_ms);
        logic taken;
        taken = 1'b0;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {now_ms, req_id, mac};
        while (!taken)
        begin
            @(posedge clk);
            taken = s_tready;
            @(negedge clk);
        end
    endtask

    // One register access: setup cycle, then access until pready.
    task automatic reg_access(input logic is_write, input logic [31:0] value);
        logic done;
        done = 1'b0;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_write;
        paddr <= LIFETIME_ADDR;
        pwdata <= is_write ? value : 32'd0;
        @(negedge clk);
        penable <= 1'b1;
        while (!done)
        begin
            @(posedge clk);
            done = pready;
            @(negedge clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Write the lifetime and read it back for the checker.
    task automatic set_lifetime(input logic [LIFE_W-1:0] value);
        reg_access(1'b1, 32'(value));
        reg_access(1'b0, 32'd0);
    endtask

    // Stop offering, wait for every verdict, then let the block go quiet.
    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        while (verdicts_owed != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Mostly well-formed traffic from a pool of sources on a running clock,
    // with newer, repeated and older ids, time jumps and some pure noise.
    task automatic run_random_phase(input int items, input int pool_size,
                                    input logic [TIME_W-1:0] start_ms);
        int pick;
        int roll;
        logic [MAC_W-1:0] mac;
        logic [ID_W-1:0] req_id;
        logic [TIME_W-1:0] now_ms;
        for (int k = 0; k < pool_size; k++)
        begin
            mac_pool[k] = {16'($urandom()), $urandom()};
            id_pool[k] = $urandom();
        end
        clock_ms = start_ms;
        for (int n = 0; n < items; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 30)
                clock_ms = clock_ms;
            else if (roll < 80)
                clock_ms = clock_ms + $urandom_range(1, 20);
            else if (roll < 95)
                clock_ms = clock_ms + $urandom_range(1, 2000);
            else if (roll < 98)
                clock_ms = clock_ms + $urandom_range(0, 70000);
            else
                clock_ms = clock_ms - $urandom_range(1, 100);

            if ($urandom_range(0, 99) < 5)
            begin
                mac = {16'($urandom()), $urandom()};
                req_id = $urandom();
                now_ms = $urandom();
            end
            else
            begin
                pick = $urandom_range(0, pool_size - 1);
                mac = mac_pool[pick];
                now_ms = clock_ms;
                roll = $urandom_range(0, 99);
                if (roll < 50)
                    req_id = id_pool[pick] + $urandom_range(1, 3);
                else if (roll < 70)
                    req_id = id_pool[pick];
                else if (roll < 85)
                    req_id = id_pool[pick] - $urandom_range(1, 5);
                else
                    req_id = $urandom();
                if (req_id > id_pool[pick])
                    id_pool[pick] = req_id;
            end
            send_request(mac, req_id, now_ms);
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_off_req = 1'b0;
        quiet_cycles = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Reset value of the lifetime, then basic table behavior.
        reg_access(1'b0, 32'd0);
        send_request(48'h0, 32'h0, 32'd0);
        send_request(48'h0, 32'h0, 32'd1);
        send_request(48'h0, 32'h1, 32'd2);
        send_request(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'd3);
        send_request(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFE, 32'd4);
        send_request(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'd5);
        // Just inside the lifetime, then exactly at it.
        send_request(48'h0, 32'h5, 32'd5601);
        send_request(48'hFFFF_FFFF_FFFF, 32'h0, 32'd5603);
        // Time running backwards, then across the wrap of the clock.
        send_request(48'h0, 32'h0, 32'd0);
        send_request(48'h1, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(48'h1, 32'h8000_0001, 32'h0);
        drain_and_settle();

        // Zero lifetime: everything expires on the next request.
        set_lifetime(16'd0);
        send_request(48'h0A0B_0C0D_0E0F, 32'd7, 32'd10);
        send_request(48'h0A0B_0C0D_0E0F, 32'd7, 32'd10);
        drain_and_settle();

        // Shortest nonzero lifetime.
        set_lifetime(16'd1);
        send_request(48'h0A0B_0C0D_0E0F, 32'd3, 32'd20);
        send_request(48'h0A0B_0C0D_0E0F, 32'd3, 32'd20);
        send_request(48'h0A0B_0C0D_0E0F, 32'd4, 32'd21);
        drain_and_settle();

        // Longest lifetime, no idling, with a long result hold-off so the
        // table fills and the block backs up to its input.
        set_lifetime(16'hFFFF);
        hold_off_req = 1'b1;
        run_random_phase(PHASE_ITEMS, 96, $urandom());
        drain_and_settle();

        // Sparse input near the clock wrap.
        set_lifetime(LIFE_W'($urandom_range(200, 5000)));
        sender_idle_pct = 88;
        receiver_stall_pct = 0;
        run_random_phase(PHASE_ITEMS, 40, 32'hFFFF_F000);
        drain_and_settle();

        // Heavy output stalls with a one-millisecond lifetime.
        set_lifetime(16'd1);
        sender_idle_pct = 0;
        receiver_stall_pct = 88;
        run_random_phase(PHASE_ITEMS, 16, $urandom());
        drain_and_settle();

        // Light idling on both sides, any nonzero lifetime.
        set_lifetime(LIFE_W'($urandom_range(1, 65535)));
        sender_idle_pct = 8;
        receiver_stall_pct = 8;
        run_random_phase(PHASE_ITEMS, 64, $urandom());
        drain_and_settle();

        if (error_count == 0 && verdicts_owed == 0)
            $display("route_request_duplicate_cache_unit_tb: clean");
        else
            $display("route_request_duplicate_cache_unit_tb: errors");
        $finish;
    end

endmodule

[route_request_duplicate_cache_unit.f]
+incdir+hdl
hdl/rrdc_pkg.sv
hdl/rrdc_table.sv
hdl/rrdc_scan_unit.sv
hdl/rrdc_ctrl.sv
hdl/route_request_duplicate_cache_unit.sv
test/route_request_duplicate_cache_checker.sv
test/route_request_duplicate_cache_unit_tb.sv
